>>> hdl/patt_pkg.sv
// ----------------------------------------------------------------------------
// patt_pkg: shared types and codes for the periodic timer table
// Operation codes, status codes and the period and skip counter widths.
// ----------------------------------------------------------------------------
`default_nettype none
package patt_pkg;
	localparam logic [2:0] OP_ADD     = 3'd0;
	localparam logic [2:0] OP_REMOVE  = 3'd1;
	localparam logic [2:0] OP_SUSPEND = 3'd2;
	localparam logic [2:0] OP_RESUME  = 3'd3;
	localparam logic [2:0] OP_QUERY   = 3'd4;
	localparam logic [2:0] OP_TICK    = 3'd5;
	localparam logic [2:0] OP_REPORT  = 3'd6;
	localparam logic [2:0] OP_NONE    = 3'd7;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NO_CHANGE = 2'd3;

	localparam int PERIOD_BITS = 31;
	localparam int SKIP_BITS   = 8;
endpackage
`default_nettype wire

>>> hdl/periodic_action_timer_table_core.sv
// ----------------------------------------------------------------------------
// periodic_action_timer_table_core: keyed periodic timer table
// Front intake queue feeding a table engine that runs commands and ticks.
// ----------------------------------------------------------------------------
// A command (add, remove, suspend, resume, query, report) is acted on once
// its beat is at the queue head, the engine is idle and the result port is
// free, and returns one acknowledge beat. A tick first advances time, then
// walks the slots one by one against the new time and, when any entry fires,
// sends the final fire from a flush state; a slot step waits while a fire
// must go out on a stalled result port. A tick returns one beat per fired
// entry, the final one marked last, and nothing when none fire. A two-beat queue
// separates intake from the engine, so new beats are taken while a tick
// walks until the queue is full.
`default_nettype none
module periodic_action_timer_table_core import patt_pkg::*; #(
	parameter int NUM_ENTRIES = 8,
	parameter int KEY_BITS    = 16,
	parameter int TIME_BITS   = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [2:0]             operation,
	input  wire logic [KEY_BITS-1:0]    entry_key,
	input  wire logic [PERIOD_BITS-1:0] interval_ticks,
	input  wire logic                   success,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        event_kind,
	output logic [KEY_BITS-1:0]         event_key,
	output logic [1:0]                  status,
	output logic                        found,
	output logic                        paused,
	output logic                        last
);
	logic                   q_valid, q_pop, q_ok;
	logic [2:0]             q_op;
	logic [KEY_BITS-1:0]    q_key;
	logic [PERIOD_BITS-1:0] q_ivl;

	patt_front #(.KEY_BITS(KEY_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready,
		.op_i(operation), .key_i(entry_key), .ivl_i(interval_ticks), .ok_i(success),
		.q_valid, .q_pop, .q_op, .q_key, .q_ivl, .q_ok
	);

	patt_back #(.NUM_ENTRIES(NUM_ENTRIES), .KEY_BITS(KEY_BITS), .TIME_BITS(TIME_BITS))
	u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_op, .q_key, .q_ivl, .q_ok,
		.out_valid, .out_ready, .event_kind, .event_key, .status, .found,
		.paused, .last
	);
endmodule
`default_nettype wire

>>> hdl/patt_front.sv
// ----------------------------------------------------------------------------
// patt_front: command intake
// Accepts input beats, drops unused codes, and queues commands for the back.
// ----------------------------------------------------------------------------
`default_nettype none
module patt_front import patt_pkg::*; #(
	parameter int KEY_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [2:0]             op_i,
	input  wire logic [KEY_BITS-1:0]    key_i,
	input  wire logic [PERIOD_BITS-1:0] ivl_i,
	input  wire logic                   ok_i,
	output logic                        q_valid,
	input  wire logic                   q_pop,
	output logic [2:0]                  q_op,
	output logic [KEY_BITS-1:0]         q_key,
	output logic [PERIOD_BITS-1:0]      q_ivl,
	output logic                        q_ok
);
	// two-entry queue
	logic [2:0]             op_q  [2];
	logic [KEY_BITS-1:0]    key_q [2];
	logic [PERIOD_BITS-1:0] ivl_q [2];
	logic                   ok_q  [2];
	logic                   wp_q, rp_q;
	logic [1:0]             cnt_q;
	logic                   push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready && (op_i != OP_NONE);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_op     = op_q[rp_q];
	assign q_key    = key_q[rp_q];
	assign q_ivl    = ivl_q[rp_q];
	assign q_ok     = ok_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wp_q]  <= op_i;
			key_q[wp_q] <= key_i;
			ivl_q[wp_q] <= (ivl_i == '0) ? PERIOD_BITS'(1) : ivl_i;
			ok_q[wp_q]  <= ok_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule
`default_nettype wire

>>> hdl/patt_back.sv
// ----------------------------------------------------------------------------
// patt_back: table engine
// Executes commands on the entry table and walks it slot by slot on a tick.
// ----------------------------------------------------------------------------
`default_nettype none
module patt_back import patt_pkg::*; #(
	parameter int NUM_ENTRIES = 8,
	parameter int KEY_BITS    = 16,
	parameter int TIME_BITS   = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_valid,
	output logic                        q_pop,
	input  wire logic [2:0]             q_op,
	input  wire logic [KEY_BITS-1:0]    q_key,
	input  wire logic [PERIOD_BITS-1:0] q_ivl,
	input  wire logic                   q_ok,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic                        event_kind,
	output logic [KEY_BITS-1:0]         event_key,
	output logic [1:0]                  status,
	output logic                        found,
	output logic                        paused,
	output logic                        last
);
	localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_WALK  = 3'b010,
		S_FLUSH = 3'b100
	} state_t;

	state_t                 state_q;
	logic [NUM_ENTRIES-1:0] valid_q, susp_q;
	logic [KEY_BITS-1:0]    key_q   [NUM_ENTRIES];
	logic [TIME_BITS-1:0]   dl_q    [NUM_ENTRIES];
	logic [PERIOD_BITS-1:0] per_q   [NUM_ENTRIES];
	logic [SKIP_BITS-1:0]   skip_q  [NUM_ENTRIES];
	logic [TIME_BITS-1:0]   time_q;
	logic [IW-1:0]          idx_q;

	// one fire held back until the next fire (or walk end) tells "last"
	logic                   pend_q;
	logic [KEY_BITS-1:0]    pend_key_q;

	logic                   ob_free;
	logic [NUM_ENTRIES-1:0] hit, free;
	logic [IW-1:0]          hit_idx, free_idx, add_idx;
	logic                   hit_any, free_any;
	logic [TIME_BITS-1:0]   diff, dl_cur;
	logic                   due, fires, walk_end;
	logic                   cmd_go, walk_step, walk_emit, flush_go, pend_next;
	logic [1:0]             cmd_status;
	logic                   cmd_found, cmd_paused;

	assign ob_free = !out_valid || out_ready;

	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		hit_any  = 1'b0;
		free_any = 1'b0;
		for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
			hit[i]  = valid_q[i] && (key_q[i] == q_key);
			free[i] = !valid_q[i];
			if (hit[i]) begin
				hit_idx = IW'(i);
				hit_any = 1'b1;
			end
			if (free[i]) begin
				free_idx = IW'(i);
				free_any = 1'b1;
			end
		end
	end

	assign add_idx = hit_any ? hit_idx : free_idx;

	// acknowledge fields for the command at the queue head
	always_comb begin
		cmd_status = ST_OK;
		cmd_found  = 1'b0;
		cmd_paused = 1'b0;
		case (q_op)
			OP_ADD: begin
				if (!hit_any && !free_any) cmd_status = ST_FULL;
			end
			OP_REMOVE, OP_REPORT: begin
				if (!hit_any) cmd_status = ST_NOT_FOUND;
			end
			OP_SUSPEND, OP_RESUME: begin
				if (!hit_any) cmd_status = ST_NOT_FOUND;
				else if (susp_q[hit_idx] == (q_op == OP_SUSPEND)) cmd_status = ST_NO_CHANGE;
			end
			OP_QUERY: begin
				if (!hit_any) cmd_status = ST_NOT_FOUND;
				else begin
					cmd_found  = 1'b1;
					cmd_paused = susp_q[hit_idx];
				end
			end
			default: ;
		endcase
	end

	assign dl_cur   = dl_q[idx_q];
	assign diff     = time_q - dl_cur;
	assign due      = valid_q[idx_q] && !diff[TIME_BITS-1];
	assign fires    = due && (skip_q[idx_q] == '0) && !susp_q[idx_q];
	assign walk_end = (idx_q == IW'(NUM_ENTRIES - 1));

	// a slot step waits only when a new fire must push out the pending one
	assign cmd_go    = (state_q == S_IDLE) && q_valid && (q_op != OP_TICK) && ob_free;
	assign walk_step = (state_q == S_WALK) && (!(fires && pend_q) || ob_free);
	assign walk_emit = walk_step && fires && pend_q;
	assign flush_go  = (state_q == S_FLUSH) && ob_free;
	assign pend_next = fires || pend_q;
	assign q_pop     = cmd_go || (walk_step && walk_end && !pend_next) || flush_go;

	always_ff @(posedge clk) begin
		if (cmd_go) begin
			event_kind <= 1'b0;
			event_key  <= q_key;
			status     <= cmd_status;
			found      <= cmd_found;
			paused     <= cmd_paused;
			last       <= 1'b1;
			if (q_op == OP_ADD && (hit_any || free_any)) begin
				key_q[add_idx]  <= q_key;
				per_q[add_idx]  <= q_ivl;
				dl_q[add_idx]   <= time_q + TIME_BITS'(q_ivl);
				skip_q[add_idx] <= '0;
			end
			if (q_op == OP_REPORT && hit_any) begin
				if (q_ok) skip_q[hit_idx] <= '0;
				else if (skip_q[hit_idx] != '1)
					skip_q[hit_idx] <= skip_q[hit_idx] + SKIP_BITS'(1);
			end
		end else if (walk_step) begin
			if (due) begin
				dl_q[idx_q] <= dl_cur + TIME_BITS'(per_q[idx_q]);
				if (skip_q[idx_q] != '0) skip_q[idx_q] <= skip_q[idx_q] - SKIP_BITS'(1);
			end
			if (fires) pend_key_q <= key_q[idx_q];
			if (walk_emit) begin
				event_kind <= 1'b1;
				event_key  <= pend_key_q;
				status     <= ST_OK;
				found      <= 1'b0;
				paused     <= 1'b0;
				last       <= 1'b0;
			end
		end else if (flush_go) begin
			// final fire of the tick
			event_kind <= 1'b1;
			event_key  <= pend_key_q;
			status     <= ST_OK;
			found      <= 1'b0;
			paused     <= 1'b0;
			last       <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			susp_q    <= '0;
			time_q    <= '0;
			idx_q     <= '0;
			pend_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd_go || walk_emit || flush_go) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid && q_op == OP_TICK) begin
						time_q  <= time_q + TIME_BITS'(1);
						idx_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= S_WALK;
					end else if (cmd_go) begin
						if (q_op == OP_ADD && (hit_any || free_any)) begin
							valid_q[add_idx] <= 1'b1;
							susp_q[add_idx]  <= 1'b0;
						end
						if (q_op == OP_REMOVE && hit_any) valid_q[hit_idx] <= 1'b0;
						if ((q_op == OP_SUSPEND || q_op == OP_RESUME) && hit_any)
							susp_q[hit_idx] <= (q_op == OP_SUSPEND);
					end
				end
				S_WALK: begin
					if (walk_step) begin
						pend_q <= pend_next;
						if (walk_end) state_q <= pend_next ? S_FLUSH : S_IDLE;
						else idx_q <= idx_q + IW'(1);
					end
				end
				S_FLUSH: begin
					if (ob_free) begin
						pend_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hdl/patt_checker.sv
// ----------------------------------------------------------------------------
// patt_checker: port-level checks for the timer table
// Watches result beats for consistent field combinations.
// ----------------------------------------------------------------------------
`default_nettype none
module patt_checker import patt_pkg::*; #(
	parameter int KEY_BITS = 16
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic                event_kind,
	input wire logic [KEY_BITS-1:0] event_key,
	input wire logic [1:0]          status,
	input wire logic                found,
	input wire logic                last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_key))
		else $error("result dropped while stalled");
	a_fire_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind |-> status == ST_OK && !found)
		else $error("fire beat carries status");
	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !event_kind |-> last)
		else $error("acknowledge not last");
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == ST_OK)
		else $error("found with error status");
endmodule

bind periodic_action_timer_table_core patt_checker #(.KEY_BITS(KEY_BITS)) u_chk (
	.clk, .arst_n, .out_valid, .out_ready, .event_kind, .event_key, .status,
	.found, .last
);
`default_nettype wire

>>> dv/periodic_action_timer_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_action_timer_table_checker: event predictor and scoreboard
// Watches both channels, keeps its own timer table and compares events.
// ----------------------------------------------------------------------------
`default_nettype none
module periodic_action_timer_table_checker import patt_pkg::*; #(
	parameter int NUM_ENTRIES = 8,
	parameter int KEY_BITS    = 16,
	parameter int TIME_BITS   = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic                   in_ready,
	input  wire logic [2:0]             operation,
	input  wire logic [KEY_BITS-1:0]    entry_key,
	input  wire logic [PERIOD_BITS-1:0] interval_ticks,
	input  wire logic                   success,
	input  wire logic                   out_valid,
	input  wire logic                   out_ready,
	input  wire logic                   event_kind,
	input  wire logic [KEY_BITS-1:0]    event_key,
	input  wire logic [1:0]             status,
	input  wire logic                   found,
	input  wire logic                   paused,
	input  wire logic                   last,
	output int                          fail_count,
	output int                          pending_events
);
	typedef struct packed {
		logic                kind;
		logic [KEY_BITS-1:0] key;
		logic [1:0]          st;
		logic                fnd;
		logic                susp;
		logic                lst;
	} timer_event_t;

	timer_event_t expected_events[$];

	logic                   slot_used [NUM_ENTRIES];
	logic [KEY_BITS-1:0]    slot_key  [NUM_ENTRIES];
	logic [TIME_BITS-1:0]   slot_due  [NUM_ENTRIES];
	logic [PERIOD_BITS-1:0] slot_per  [NUM_ENTRIES];
	logic                   slot_held [NUM_ENTRIES];
	logic [SKIP_BITS-1:0]   slot_skip [NUM_ENTRIES];
	logic [TIME_BITS-1:0]   now_ticks;

	task automatic clear_table();
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			slot_used[i] = 1'b0;
			slot_key[i]  = '0;
			slot_due[i]  = '0;
			slot_per[i]  = '0;
			slot_held[i] = 1'b0;
			slot_skip[i] = '0;
		end
		now_ticks = '0;
	endtask

	// Apply one command beat to the table and queue the events it causes.
	task automatic advance_table(input logic [2:0] op, input logic [KEY_BITS-1:0] key,
			input logic [PERIOD_BITS-1:0] ivl, input logic ok);
		int hit;
		int fires;
		logic [TIME_BITS-1:0] lag;
		timer_event_t ev;
		hit = -1;
		fires = 0;
		ev = '0;
		ev.key = key;
		ev.lst = 1'b1;
		for (int i = NUM_ENTRIES - 1; i >= 0; i--)
			if (slot_used[i] && slot_key[i] == key)
				hit = i;
		case (op)
			OP_ADD: begin
				if (ivl == '0)
					ivl = PERIOD_BITS'(1);
				if (hit < 0)
					for (int i = NUM_ENTRIES - 1; i >= 0; i--)
						if (!slot_used[i])
							hit = i;
				if (hit < 0) begin
					ev.st = ST_FULL;
				end else begin
					slot_used[hit] = 1'b1;
					slot_key[hit]  = key;
					slot_per[hit]  = ivl;
					slot_due[hit]  = now_ticks + TIME_BITS'(ivl);
					slot_held[hit] = 1'b0;
					slot_skip[hit] = '0;
				end
			end
			OP_REMOVE: begin
				if (hit < 0)
					ev.st = ST_NOT_FOUND;
				else
					slot_used[hit] = 1'b0;
			end
			OP_SUSPEND, OP_RESUME: begin
				if (hit < 0)
					ev.st = ST_NOT_FOUND;
				else if (slot_held[hit] == (op == OP_SUSPEND))
					ev.st = ST_NO_CHANGE;
				else
					slot_held[hit] = (op == OP_SUSPEND);
			end
			OP_QUERY: begin
				if (hit < 0) begin
					ev.st = ST_NOT_FOUND;
				end else begin
					ev.fnd  = 1'b1;
					ev.susp = slot_held[hit];
				end
			end
			OP_TICK: begin
				now_ticks = now_ticks + TIME_BITS'(1);
				for (int i = 0; i < NUM_ENTRIES; i++) begin
					lag = now_ticks - slot_due[i];
					if (slot_used[i] && !lag[TIME_BITS-1]) begin
						slot_due[i] = slot_due[i] + TIME_BITS'(slot_per[i]);
						if (slot_skip[i] != '0) begin
							slot_skip[i] = slot_skip[i] - SKIP_BITS'(1);
						end else if (!slot_held[i]) begin
							ev = '0;
							ev.kind = 1'b1;
							ev.key  = slot_key[i];
							expected_events.push_back(ev);
							fires++;
						end
					end
				end
				// only the final fire of a tick carries last
				if (fires > 0)
					expected_events[$].lst = 1'b1;
			end
			OP_REPORT: begin
				if (hit < 0)
					ev.st = ST_NOT_FOUND;
				else if (ok)
					slot_skip[hit] = '0;
				else if (slot_skip[hit] != '1)
					slot_skip[hit] = slot_skip[hit] + SKIP_BITS'(1);
			end
			default: ;
		endcase
		if (op != OP_TICK && op <= OP_REPORT)
			expected_events.push_back(ev);
	endtask

	always @(posedge clk or negedge arst_n) begin
		timer_event_t want;
		if (!arst_n) begin
			clear_table();
			expected_events.delete();
			fail_count <= 0;
			pending_events <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					$error("unexpected event beat key=%0h", event_key);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_events.pop_front();
					if ({event_kind, event_key, status, found, paused, last} !== want)
						fail_count <= fail_count + 1;
					if (event_kind !== want.kind)
						$error("event_kind expected %0h got %0h", want.kind, event_kind);
					if (event_key !== want.key)
						$error("event_key expected %0h got %0h", want.key, event_key);
					if (status !== want.st)
						$error("status expected %0h got %0h", want.st, status);
					if (found !== want.fnd)
						$error("found expected %0h got %0h", want.fnd, found);
					if (paused !== want.susp)
						$error("paused expected %0h got %0h", want.susp, paused);
					if (last !== want.lst)
						$error("last expected %0h got %0h", want.lst, last);
				end
			end
			if (in_valid && in_ready)
				advance_table(operation, entry_key, interval_ticks, success);
			pending_events <= expected_events.size();
		end
	end
endmodule
`default_nettype wire

>>> dv/tb_periodic_action_timer_table_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_periodic_action_timer_table_core: testbench for the timer table
// Directed commands, a skip saturation burst and weighted random traffic,
// with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_periodic_action_timer_table_core;
	import patt_pkg::*;

	localparam int NUM_ENTRIES = 8;
	localparam int KEY_BITS    = 16;
	localparam int TIME_BITS   = 32;
	localparam int RANDOM_BEATS = 20;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int STALL_BEAT   = 40;   // event beat after which the sink stalls
	localparam int STALL_CYCLES = 400;
	localparam int DRAIN_CYCLES = 4 * NUM_ENTRIES + 8;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [2:0]             operation = OP_QUERY;
	logic [KEY_BITS-1:0]    entry_key = '0;
	logic [PERIOD_BITS-1:0] interval_ticks = '0;
	logic                   success = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   event_kind;
	logic [KEY_BITS-1:0]    event_key;
	logic [1:0]             status;
	logic                   found;
	logic                   paused;
	logic                   last;
	int                     fail_count;
	int                     pending_events;
	int                     cycle_count = 0;
	int                     sink_beats = 0;
	logic [KEY_BITS-1:0]    key_pool[12];

	always #5 clk = ~clk;

	periodic_action_timer_table_core #(
		.NUM_ENTRIES(NUM_ENTRIES), .KEY_BITS(KEY_BITS), .TIME_BITS(TIME_BITS)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .entry_key(entry_key),
		.interval_ticks(interval_ticks), .success(success),
		.out_valid(out_valid), .out_ready(out_ready),
		.event_kind(event_kind), .event_key(event_key), .status(status),
		.found(found), .paused(paused), .last(last)
	);

	periodic_action_timer_table_checker #(
		.NUM_ENTRIES(NUM_ENTRIES), .KEY_BITS(KEY_BITS), .TIME_BITS(TIME_BITS)
	) checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .entry_key(entry_key),
		.interval_ticks(interval_ticks), .success(success),
		.out_valid(out_valid), .out_ready(out_ready),
		.event_kind(event_kind), .event_key(event_key), .status(status),
		.found(found), .paused(paused), .last(last),
		.fail_count(fail_count), .pending_events(pending_events)
	);

	// Watchdog: covers worst-case gaps, 8 fires per tick and sink stalls.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_periodic_action_timer_table_core NOT OK");
			$finish;
		end
	end

	// Sink: random hold-off per beat, plus one long stall so the intake
	// queue fills and in_ready drops while the source keeps offering.
	initial begin
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = $urandom_range(0, 16);
			if (sink_beats == STALL_BEAT)
				gap = STALL_CYCLES;
			else if ((sink_beats / 64) % 2 == 1)
				gap = 0;     // stretch with no sink gaps
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sink_beats++;
			@(negedge clk);
		end
	end

	// Offer one command beat; caller sits on a falling edge.
	task automatic send_beat(input logic [2:0] op, input logic [KEY_BITS-1:0] key,
			input logic [PERIOD_BITS-1:0] ivl, input logic ok, input bit busy);
		int gap;
		gap = busy ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid       <= 1'b1;
		operation      <= op;
		entry_key      <= key;
		interval_ticks <= ivl;
		success        <= ok;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	function automatic logic [PERIOD_BITS-1:0] pick_interval();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return PERIOD_BITS'($urandom_range(0, 6));
		else if (r < 85)
			return PERIOD_BITS'($urandom_range(7, 40));
		return PERIOD_BITS'($urandom);
	endfunction

	initial begin
		logic [2:0]          op;
		logic [KEY_BITS-1:0] key;
		int                  r;
		bit                  busy;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < 12; i++)
			key_pool[i] = KEY_BITS'($urandom);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, every operation, each corner
		send_beat(OP_QUERY, '0, '0, 1'b0, 0);          // query on empty table
		send_beat(OP_ADD, '0, '0, 1'b0, 0);            // zero interval -> one
		send_beat(OP_ADD, '1, '1, 1'b1, 0);            // max interval, never due
		send_beat(OP_QUERY, '1, '0, 1'b0, 0);
		send_beat(OP_SUSPEND, '1, '0, 1'b0, 0);
		send_beat(OP_SUSPEND, '1, '0, 1'b0, 0);        // already suspended
		send_beat(OP_QUERY, '1, '0, 1'b0, 0);
		send_beat(OP_RESUME, '1, '0, 1'b0, 0);
		send_beat(OP_RESUME, '1, '0, 1'b0, 0);         // already running
		send_beat(OP_TICK, '0, '0, 1'b0, 0);
		send_beat(OP_REPORT, '0, '0, 1'b0, 0);         // failure -> skip one
		send_beat(OP_TICK, '0, '0, 1'b0, 0);           // skipped fire
		send_beat(OP_REPORT, '0, '0, 1'b1, 0);
		send_beat(OP_REPORT, 16'h1234, '0, 1'b1, 0);   // missing key
		send_beat(OP_SUSPEND, 16'h1234, '0, 1'b0, 0);
		send_beat(OP_ADD, '0, 31'd3, 1'b0, 0);         // replace in place
		send_beat(OP_NONE, '1, '1, 1'b1, 0);           // unused code, ignored
		send_beat(OP_REMOVE, '1, '0, 1'b0, 0);
		send_beat(OP_REMOVE, '1, '0, 1'b0, 0);         // missing after remove
		for (int i = 1; i <= NUM_ENTRIES; i++)         // last one hits full
			send_beat(OP_ADD, KEY_BITS'(16'h0100 + i), 31'd1, 1'b0, 0);
		send_beat(OP_TICK, '0, '0, 1'b0, 0);           // full table fires

		// skip counter saturation on key 0x0101, then clear it
		for (int i = 0; i < 258; i++)
			send_beat(OP_REPORT, 16'h0101, '0, 1'b0, i > 4);
		repeat (3) send_beat(OP_TICK, '0, '0, 1'b0, 0);
		send_beat(OP_REPORT, 16'h0101, '0, 1'b1, 0);
		for (int i = 1; i <= NUM_ENTRIES; i++)
			send_beat(OP_REMOVE, KEY_BITS'(16'h0100 + i), '0, 1'b0, 1);

		// random: mostly pool keys so entries live, fire and collide
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 35)      op = OP_TICK;
			else if (r < 55) op = OP_ADD;
			else if (r < 63) op = OP_REMOVE;
			else if (r < 71) op = OP_SUSPEND;
			else if (r < 79) op = OP_RESUME;
			else if (r < 87) op = OP_QUERY;
			else if (r < 97) op = OP_REPORT;
			else             op = OP_NONE;
			if ($urandom_range(0, 9) == 0)
				key = KEY_BITS'($urandom);
			else
				key = key_pool[$urandom_range(0, 11)];
			busy = ((n / 5) % 2 == 1);                 // back-to-back stretch
			send_beat(op, key, pick_interval(), 1'($urandom), busy);
		end
		in_valid <= 1'b0;

		while (pending_events != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending_events == 0)
			$display("tb_periodic_action_timer_table_core OK");
		else
			$display("tb_periodic_action_timer_table_core NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
